// ===== rtl/sha_pkg.sv =====
// Package for the SHA-256 stream hash: round constants, initial hash values, state type.
// No dependencies.
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] v, input int unsigned s);
    ror = (v >> s) | (v << (WordW - s));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_if.sv =====
// Valid/ready stream interfaces for the SHA-256 stream hash.
// Depends on nothing.
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       final_item;
  modport source (output valid, data_byte, has_byte, final_item, input ready);
  modport sink (input valid, data_byte, has_byte, final_item, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read before write: a read of the address being written returns the old value.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hash.sv =====
// SHA-256 stream hash: at most one byte per input item, eight digest words per message.
// Bytes are taken while a block fills; a full block then runs the rounds, each split into a
// read phase and a use phase by the registered schedule RAM read, and then the chaining
// update, with input held off. A final item is followed by padding, one byte at a time to
// the block end, up to two padding blocks, and then by the eight digest words.
// Synchronous active-high reset restores the initial hash values and clears all counters.
`default_nettype none
module sha256_stream_hash (
  input wire logic clk,
  input wire logic rst,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  state_t state, state_next;
  logic [31:0] chain [8];
  logic [31:0] wk [8];
  logic [63:0] bit_length;
  logic [5:0]  byte_in_block;
  logic [6:0]  round_number;
  logic [31:0] fill_word;     // bytes of the current word being gathered
  logic        pad_final;     // the final item of the message has been taken
  logic        pad_started;   // 0x80 already placed
  logic        len_block;     // the current padding block carries the length
  logic [2:0]  out_idx;
  logic        sub;           // schedule read phase inside a round

  // Schedule window: sixteen words of 32 bits, held in four RAMs so that the four taps
  // of the expansion come out in the same cycle.
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ra0, ra1, ra2, ra3;
  logic [31:0] rd0, rd1, rd2, rd3;

  sha_ram #(.Width(32), .Depth(16)) u_w16 (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(ram_wdata), .raddr(ra0), .rdata(rd0));
  sha_ram #(.Width(32), .Depth(16)) u_w15 (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(ram_wdata), .raddr(ra1), .rdata(rd1));
  sha_ram #(.Width(32), .Depth(16)) u_w7 (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(ram_wdata), .raddr(ra2), .rdata(rd2));
  sha_ram #(.Width(32), .Depth(16)) u_w2 (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(ram_wdata), .raddr(ra3), .rdata(rd3));

  // A round has a read phase and a use phase: sub 0 issues reads, sub 1 uses data and writes back.
  // That interlock keeps round t+1 from reading before round t has written its word.
  logic [3:0]  slot;
  logic [31:0] s0, s1, w, t1, t2, wnew;
  assign slot = round_number[3:0];
  assign ra0 = slot;
  assign ra1 = slot + 4'd1;
  assign ra2 = slot + 4'd9;
  assign ra3 = slot + 4'd14;

  always_comb begin
    s0 = ror(rd1, 7) ^ ror(rd1, 18) ^ (rd1 >> 3);
    s1 = ror(rd3, 17) ^ ror(rd3, 19) ^ (rd3 >> 10);
    wnew = rd0 + s0 + rd2 + s1;
    w = (round_number[6:4] == 3'd0) ? rd0 : wnew;
    t1 = wk[7] + (ror(wk[4], 6) ^ ror(wk[4], 11) ^ ror(wk[4], 25))
       + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6])) + RoundK[round_number[5:0]] + w;
    t2 = (ror(wk[0], 2) ^ ror(wk[0], 13) ^ ror(wk[0], 22))
       + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
  end

  // Byte placed into the gathered word during fill and padding.
  logic [7:0]  pad_byte;
  logic [31:0] merged;
  logic        accept;
  assign accept = in_ch.valid && in_ch.ready;

  // The length goes only into the last padding block; padding bytes after 0x80 are otherwise zero.
  always_comb begin
    if (!pad_started) begin
      pad_byte = PadByte;
    end else if (len_block && byte_in_block >= LenPos) begin
      pad_byte = bit_length[8*(7-byte_in_block[2:0]) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  logic [7:0] put_byte;
  logic       put_en;
  always_comb begin
    put_byte = (state == ST_PAD) ? pad_byte : in_ch.data_byte;
    put_en = (state == ST_PAD) || (accept && in_ch.has_byte);
    merged = fill_word;
    merged[8*(3-byte_in_block[1:0]) +: 8] = put_byte;
  end

  // RAM write port: gathered words in fill/pad, expanded words in rounds.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = byte_in_block[5:2];
    ram_wdata = merged;
    if (put_en && byte_in_block[1:0] == 2'd3) begin
      ram_we = 1'b1;
    end
    if (state == ST_ROUND) begin
      ram_we = sub && (round_number[6:4] != 3'd0);
      ram_waddr = slot;
      ram_wdata = wnew;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (accept) begin
          if (in_ch.has_byte && byte_in_block == 6'd63) begin
            state_next = ST_ROUND;
          end else if (in_ch.final_item) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (byte_in_block == 6'd63) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sub && round_number == 7'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!pad_final) begin
          state_next = ST_FILL;
        end else if (len_block) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ch.ready && out_idx == 3'd7) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // Outputs of the handshake.
  always_comb begin
    in_ch.ready = (state == ST_FILL);
    out_ch.valid = (state == ST_OUT);
    out_ch.digest_word = chain[out_idx];
    out_ch.word_index = out_idx;
    out_ch.last_word = (out_idx == 3'd7);
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      bit_length <= '0;
      byte_in_block <= '0;
      round_number <= '0;
      pad_final <= 1'b0;
      pad_started <= 1'b0;
      len_block <= 1'b0;
      out_idx <= '0;
      sub <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= InitHash[i];
        wk[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (put_en) begin
        fill_word <= merged;
        byte_in_block <= byte_in_block + 6'd1;
      end
      case (state)
        ST_FILL: begin
          if (accept) begin
            if (in_ch.has_byte) begin
              bit_length <= bit_length + 64'd8;
            end
            pad_final <= in_ch.final_item;
          end
          for (int i = 0; i < 8; i++) begin
            wk[i] <= chain[i];
          end
        end
        ST_PAD: begin
          pad_started <= 1'b1;
          // The length fits behind 0x80 only if 0x80 lands before the length field.
          if (!pad_started) begin
            len_block <= (byte_in_block < LenPos);
          end
          for (int i = 0; i < 8; i++) begin
            wk[i] <= chain[i];
          end
        end
        ST_ROUND: begin
          sub <= ~sub;
          if (sub) begin
            wk[7] <= wk[6]; wk[6] <= wk[5]; wk[5] <= wk[4];
            wk[4] <= wk[3] + t1;
            wk[3] <= wk[2]; wk[2] <= wk[1]; wk[1] <= wk[0];
            wk[0] <= t1 + t2;
            round_number <= round_number + 7'd1;
          end
        end
        ST_ADD: begin
          round_number <= '0;
          // A padding block without the length is followed by one that carries it.
          if (pad_final && pad_started) begin
            len_block <= 1'b1;
          end
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + wk[i];
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              bit_length <= '0;
              pad_final <= 1'b0;
              pad_started <= 1'b0;
              len_block <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= InitHash[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sha_check.sv =====
// Port-level checker for the SHA-256 stream hash, bound to the top level.
// Depends on sha256_stream_hash, its bind target, and through it on sha_if.
`default_nettype none
module sha_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] word_index,
  input wire logic last_word
);
  // Input is never taken while a digest is being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input ready during digest output");
  // last_word marks index seven and only it.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last_word mismatch");
  // Words advance one index per delivered item.
  a_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && word_index != 3'd7) |=> (out_valid &&
      word_index == $past(word_index) + 3'd1)) else $error("word index skipped");
  // A digest starts at index zero.
  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_index == 3'd0)) else $error("digest not at word zero");
endmodule

bind sha256_stream_hash sha_check u_check (
  .clk, .rst, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);
`default_nettype wire
